// ===== rtl/assert_macros.svh =====
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("check failed");
`define HBA_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("check failed");
`else
`define HBA_ASSERT(lbl, clk, rst, prop)
`define HBA_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/hba_pkg.sv =====
package hba_pkg;
   localparam int unsigned BIT_CAPACITY_DEF = 65536;
   localparam int unsigned WORD_SHIFT   = 6;
   localparam int unsigned WORD_BITS    = 64;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_TEST  = 2'd2;
   localparam logic [1:0] CMD_FIND  = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] bit_index;
      logic [16:0] run_length;
   } hba_req_type;

   typedef struct packed {
      logic [16:0] set_count;
      logic        bit_is_set;
      logic        free_found;
      logic [15:0] free_index;
   } hba_rsp_type;

   function automatic logic [6:0] lowest_one(input logic [63:0] w);
      logic [6:0] r;
      r = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (w[i]) r = 7'(i);
      end
      return r;
   endfunction

   function automatic logic [63:0] low_ones(input logic [6:0] n);
      logic [63:0] r;
      r = (n >= 7'd64) ? '1 : ((64'd1 << n) - 64'd1);
      return r;
   endfunction
endpackage

// ===== rtl/hba_leaf_ram.sv =====
module hba_leaf_ram import hba_pkg::*; #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data
);
   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/hierarchical_bitmap_allocator.sv =====
// Steps: clear writes every leaf word; test reads a leaf word, then checks its bit; an
// out-of-range command goes straight to the result; set run reads, then writes, each leaf
// word touched; next-free search reads and checks each word scanned, plus a read per range
// end reached. One command at a time; the next is taken the cycle after the result is
// loaded; a stalled result holds the next in ST_DONE until taken. Reset: synchronous;
// a clearing pass writes every leaf word, no command taken; limit resets to BIT_CAPACITY.
`include "assert_macros.svh"
module hierarchical_bitmap_allocator import hba_pkg::*; #(
   parameter int unsigned BIT_CAPACITY = BIT_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hba_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hba_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);
   localparam int unsigned LEAF_DEPTH = (BIT_CAPACITY + WORD_BITS - 1) >> WORD_SHIFT;
   localparam int unsigned OFF_W = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
   localparam logic [16:0] MaxBits = 17'(BIT_CAPACITY);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SET_RD, ST_SET_WR, ST_TEST_RD, ST_TEST_CHK,
      ST_FIND_RD, ST_FIND_CHK, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [16:0] limit_ff;
   logic [16:0] idx_ff, rem_ff, cnt_ff;
   logic [OFF_W:0] off_ff, clr_ff;
   logic [5:0]  from_pos_ff;
   logic        wrap_ff, first_ff, clr_done_ff;
   logic        isset_ff, found_ff;
   logic [15:0] where_ff;
   logic        rsp_valid_ff;
   hba_rsp_type rsp_ff;

   logic [OFF_W-1:0] rd_addr, wr_addr;
   logic [63:0] rd_data, wr_data;
   logic        wr_en;

   hba_leaf_ram #(.DEPTH(LEAF_DEPTH), .AW(OFF_W)) u_leaf (
      .clock(clock), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   // set-run word update
   logic [5:0]  pos;
   logic [6:0]  room, chunk, got;
   logic [63:0] overlap, set_mask;
   logic [16:0] rem_next;
   // search word
   logic [63:0] free_bits;
   logic [6:0]  free_pos;
   logic [16:0] free_p, off_base;
   logic        search_end;
   // accept
   logic        accept, in_range;
   logic [16:0] acc_idx, acc_avail, acc_next;

   always_comb begin
      pos      = idx_ff[5:0];
      room     = 7'd64 - {1'b0, pos};
      chunk    = (rem_ff < 17'(room)) ? rem_ff[6:0] : room;
      overlap  = rd_data & (low_ones(chunk) << pos);
      got      = (overlap == '0) ? chunk : (lowest_one(overlap) - {1'b0, pos});
      set_mask = low_ones(got) << pos;
      rem_next = rem_ff - 17'(got);

      free_bits = ~rd_data;
      if (first_ff) free_bits = free_bits & ('1 << from_pos_ff);
      free_pos   = lowest_one(free_bits);
      off_base   = 17'({off_ff, 6'd0});
      free_p     = off_base + 17'(free_pos);
      search_end = off_ff[OFF_W] || (off_base >= limit_ff);

      accept    = req_valid && !req_stall;
      acc_idx   = {1'b0, req_data.bit_index};
      in_range  = acc_idx < limit_ff;
      acc_avail = limit_ff - acc_idx;
      acc_next  = ((acc_idx + 17'd1) == limit_ff) ? '0 : acc_idx + 17'd1;

      rd_addr = (state_ff == ST_FIND_RD) ? off_ff[OFF_W-1:0] : idx_ff[OFF_W+5:6];
      wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_SET_WR);
      wr_addr = (state_ff == ST_CLEAR) ? clr_ff[OFF_W-1:0] : idx_ff[OFF_W+5:6];
      wr_data = (state_ff == ST_CLEAR) ? '0 : (rd_data | set_mask);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_done_ff  <= 1'b0;
         limit_ff     <= MaxBits;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= (csr_wr_data > MaxBits) ? MaxBits : csr_wr_data;
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (OFF_W + 1)'(LEAF_DEPTH - 1)) begin
                  state_ff <= clr_done_ff ? ST_DONE : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cnt_ff   <= '0;
                  isset_ff <= 1'b0;
                  found_ff <= 1'b0;
                  where_ff <= '0;
                  idx_ff   <= acc_idx;
                  case (req_data.cmd)
                     CMD_CLEAR: begin
                        clr_ff      <= '0;
                        clr_done_ff <= 1'b1;
                        state_ff    <= ST_CLEAR;
                     end
                     CMD_SET: begin
                        if (in_range && req_data.run_length != '0) begin
                           rem_ff   <= (req_data.run_length < acc_avail) ?
                                       req_data.run_length : acc_avail;
                           state_ff <= ST_SET_RD;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     CMD_TEST: begin
                        state_ff <= in_range ? ST_TEST_RD : ST_DONE;
                     end
                     CMD_FIND: begin
                        if (in_range) begin
                           off_ff      <= (OFF_W + 1)'(acc_next >> WORD_SHIFT);
                           from_pos_ff <= acc_next[5:0];
                           wrap_ff     <= (acc_next != '0);
                           first_ff    <= 1'b1;
                           state_ff    <= ST_FIND_RD;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_SET_RD: state_ff <= ST_SET_WR;
            ST_SET_WR: begin
               cnt_ff <= cnt_ff + 17'(got);
               idx_ff <= idx_ff + 17'(got);
               rem_ff <= rem_next;
               state_ff <= (got != chunk || rem_next == '0) ? ST_DONE : ST_SET_RD;
            end
            ST_TEST_RD: state_ff <= ST_TEST_CHK;
            ST_TEST_CHK: begin
               isset_ff <= rd_data[pos];
               state_ff <= ST_DONE;
            end
            ST_FIND_RD: begin
               if (search_end) begin
                  if (wrap_ff) begin
                     wrap_ff     <= 1'b0;
                     off_ff      <= '0;
                     from_pos_ff <= '0;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  state_ff <= ST_FIND_CHK;
               end
            end
            ST_FIND_CHK: begin
               first_ff <= 1'b0;
               if (free_bits != '0) begin
                  if (free_p < limit_ff) begin
                     found_ff <= 1'b1;
                     where_ff <= free_p[15:0];
                     state_ff <= ST_DONE;
                  end else if (wrap_ff) begin
                     wrap_ff     <= 1'b0;
                     off_ff      <= '0;
                     from_pos_ff <= '0;
                     state_ff    <= ST_FIND_RD;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  off_ff   <= off_ff + 1'b1;
                  state_ff <= ST_FIND_RD;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.set_count   <= cnt_ff;
                  rsp_ff.bit_is_set  <= isset_ff;
                  rsp_ff.free_found  <= found_ff;
                  rsp_ff.free_index  <= where_ff;
                  clr_done_ff        <= 1'b0;
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `HBA_ASSERT(a_busy_stalls, clock, reset, (state_ff != ST_IDLE) |-> req_stall)
   `HBA_ASSERT(a_no_index_without_find, clock, reset, rsp_valid |-> (rsp_data.free_found || rsp_data.free_index == '0))
   `HBA_NEVER(a_one_kind_of_result, clock, reset, rsp_valid && (rsp_data.set_count != '0) && (rsp_data.bit_is_set || rsp_data.free_found))
   `HBA_NEVER(a_write_only_when_busy, clock, reset, wr_en && (state_ff == ST_IDLE))
endmodule
